// ===== rtl/fust_pkg.sv =====
// Shared types for the first unique symbol tracker: cell commands and controller states.
package fust_pkg;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_REMOVE,
        OP_APPEND
    } fust_op_t;

    typedef struct packed {
        logic     capture;
        fust_op_t op;
    } fust_ctl_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } fust_state_t;

endpackage

// ===== rtl/fust_rep_map.sv =====
// Bitmap memory of symbols seen more than once, one write port and one registered read port.
module fust_rep_map #(
    parameter int SYMBOL_BITS = 8
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [SYMBOL_BITS-1:0] wr_addr,
    input  logic                   wr_data,
    input  logic                   rd_en,
    input  logic [SYMBOL_BITS-1:0] rd_addr,
    output logic                   rd_data
);

    localparam int DEPTH = 1 << SYMBOL_BITS;

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fust_cell.sv =====
// One cell of the once-seen symbol list: holds one entry, compares, closes up and appends.
module fust_cell #(
    parameter int SYMBOL_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fust_pkg::fust_ctl_t      ctl,
    input  logic [SYMBOL_BITS-1:0]   sym,
    input  logic                     carry_in,
    output logic                     carry_out,
    input  logic                     left_valid,
    input  logic                     right_valid,
    input  logic [SYMBOL_BITS-1:0]   right_data,
    output logic                     valid,
    output logic [SYMBOL_BITS-1:0]   data,
    output logic                     valid_next,
    output logic [SYMBOL_BITS-1:0]   data_next
);

    import fust_pkg::*;

    logic                   valid_reg;
    logic [SYMBOL_BITS-1:0] data_reg;
    logic                   match_reg;
    logic                   match_next;

    assign match_next = ctl.capture ? (valid_reg && (data_reg == sym)) : match_reg;
    assign carry_out  = carry_in | match_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctl.op)
            OP_REMOVE:
            begin
                if (carry_out)
                begin
                    valid_next = right_valid;
                    data_next  = right_data;
                end
            end
            OP_APPEND:
            begin
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    data_next  = sym;
                end
            end
            default:
            begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== rtl/first_unique_symbol_tracker.sv =====
// Top level of the first unique symbol tracker: controller, repeated-symbol map and cell chain.
// Per item, the transfer edge reads the repeated map and latches the per-cell compares, and
// the update edge, held while a result is stalled, updates the cells and the result register.
// The result is offered in the cycle after the update; one item is in flight at a time.
// After reset a clearing pass zeroes all 2^SYMBOL_BITS map entries before items are taken.
module first_unique_symbol_tracker #(
    parameter int SYMBOL_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] symbol,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       found,
    output logic [7:0] first_unique
);

    import fust_pkg::*;

    localparam int NUM_CELLS = 1 << SYMBOL_BITS;

    fust_state_t            state_reg;
    fust_state_t            state_next;
    logic [SYMBOL_BITS-1:0] clr_addr_reg;
    logic [SYMBOL_BITS-1:0] clr_addr_next;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    logic                   found_reg;
    logic [7:0]             first_unique_reg;

    logic                   accept;
    logic                   go;
    logic                   present;
    logic                   rep_hit;
    logic                   map_wr_en;
    logic [SYMBOL_BITS-1:0] map_wr_addr;
    logic                   map_wr_data;
    logic [SYMBOL_BITS-1:0] sym_in;
    logic [SYMBOL_BITS-1:0] cell_sym;
    fust_ctl_t              ctl;

    logic                   cell_valid [NUM_CELLS];
    logic [SYMBOL_BITS-1:0] cell_data [NUM_CELLS];
    logic                   cell_valid_next [NUM_CELLS];
    logic [SYMBOL_BITS-1:0] cell_data_next [NUM_CELLS];
    logic [NUM_CELLS:0]     carry;

    assign sym_in = SYMBOL_BITS'(symbol);
    assign accept = item_valid && !item_stall;
    assign present = carry[NUM_CELLS];
    assign go = (state_reg == ST_LOOK) && (!result_valid_reg || !result_stall);

    // The cells compare against the incoming symbol at the transfer edge and append the held one.
    assign cell_sym = (state_reg == ST_IDLE) ? sym_in : sym_reg;

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        item_stall        = 1'b1;
        map_wr_en         = 1'b0;
        map_wr_addr       = sym_reg;
        map_wr_data       = 1'b1;
        ctl.capture       = 1'b0;
        ctl.op            = OP_NONE;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            ST_CLEAR:
            begin
                map_wr_en     = 1'b1;
                map_wr_addr   = clr_addr_reg;
                map_wr_data   = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {SYMBOL_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                ctl.capture = item_valid;
                if (item_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (go)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                    if (!rep_hit)
                    begin
                        ctl.op    = present ? OP_REMOVE : OP_APPEND;
                        map_wr_en = present;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg <= sym_in;
        end
        if (go)
        begin
            found_reg        <= cell_valid_next[0];
            first_unique_reg <= cell_valid_next[0] ? 8'(cell_data_next[0]) : 8'd0;
        end
    end

    fust_rep_map #(
        .SYMBOL_BITS(SYMBOL_BITS)
    ) u_rep_map (
        .clk    (clk),
        .wr_en  (map_wr_en),
        .wr_addr(map_wr_addr),
        .wr_data(map_wr_data),
        .rd_en  (accept),
        .rd_addr(sym_in),
        .rd_data(rep_hit)
    );

    assign carry[0] = 1'b0;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic                   left_valid;
        logic                   right_valid;
        logic [SYMBOL_BITS-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_valid = 1'b1;
        end
        else
        begin : g_mid
            assign left_valid = cell_valid[i-1];
        end

        if (i == NUM_CELLS - 1)
        begin : g_last
            assign right_valid = 1'b0;
            assign right_data  = '0;
        end
        else
        begin : g_inner
            assign right_valid = cell_valid[i+1];
            assign right_data  = cell_data[i+1];
        end

        fust_cell #(
            .SYMBOL_BITS(SYMBOL_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .sym        (cell_sym),
            .carry_in   (carry[i]),
            .carry_out  (carry[i+1]),
            .left_valid (left_valid),
            .right_valid(right_valid),
            .right_data (right_data),
            .valid      (cell_valid[i]),
            .data       (cell_data[i]),
            .valid_next (cell_valid_next[i]),
            .data_next  (cell_data_next[i])
        );
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign first_unique = first_unique_reg;

endmodule

// ===== tb/first_unique_symbol_tracker_test.sv =====
// Testbench for first_unique_symbol_tracker: random symbol stream checked by a predictor.
`timescale 1ns / 100ps

module first_unique_symbol_tracker_test;

    localparam int SYMBOL_COUNT     = 256;
    localparam int ITEM_COUNT       = 1900;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 60;

    typedef struct {
        logic       found;
        logic [7:0] first_unique;
    } tracker_result_t;

    class unique_scoreboard;
        bit              repeated_seen [SYMBOL_COUNT];
        logic [7:0]      once_seen [$];
        tracker_result_t pending_results [$];
        int              errors;

        function void note_symbol(logic [7:0] sym);
            tracker_result_t res;
            int              pos;
            pos = -1;
            if (!repeated_seen[sym])
            begin
                foreach (once_seen[i])
                begin
                    if (once_seen[i] == sym)
                        pos = i;
                end
                if (pos >= 0)
                begin
                    repeated_seen[sym] = 1'b1;
                    once_seen.delete(pos);
                end
                else if (once_seen.size() < SYMBOL_COUNT)
                    once_seen.insert(once_seen.size(), sym);
            end
            res.found        = (once_seen.size() > 0);
            res.first_unique = res.found ? once_seen[0] : 8'h00;
            pending_results.insert(pending_results.size(), res);
        endfunction

        task report(string msg);
            errors++;
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic got_found, logic [7:0] got_first);
            tracker_result_t want;
            if (pending_results.size() == 0)
                report($sformatf("result transfer with nothing pending (found=%b first=%02h)",
                                 got_found, got_first));
            else
            begin
                want = pending_results.pop_front();
                if (got_found !== want.found)
                    report($sformatf("found is %b, predicted %b", got_found, want.found));
                if (got_first !== want.first_unique)
                    report($sformatf("first_unique is %02h, predicted %02h",
                                     got_first, want.first_unique));
            end
        endtask
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic [7:0] symbol       = 8'h00;
    logic       result_stall = 1'b0;
    logic       item_stall;
    logic       result_valid;
    logic       found;
    logic [7:0] first_unique;

    unique_scoreboard sb = new();
    int               cycle_count;
    int               sent_count;
    int               results_seen;
    int               hold_left;

    first_unique_symbol_tracker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .symbol       (symbol),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .first_unique (first_unique)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver checks each result transfer, then holds off at random, long once, none in some runs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                sb.check_result(found, first_unique);
                results_seen++;
                if (results_seen == LONG_HOLD_AT)
                    hold_left = LONG_HOLD_CYCLES;
                else if ((results_seen / 40) % 4 == 2)
                    hold_left = 0;
                else
                    hold_left = $urandom_range(0, 5);
            end
            else if (hold_left > 0)
                hold_left--;
            result_stall <= (hold_left > 0);
        end
    end

    task automatic send_symbol(input logic [7:0] sym);
        int gap;
        gap = ((sent_count / 50) % 4 == 3) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        symbol     <= sym;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_symbol(sym);
        sent_count++;
    endtask

    initial
    begin
        logic [7:0] fill_order [$];
        logic [7:0] rest [$];
        logic [7:0] lead [$];
        int         idx;
        int         guard;

        lead = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F, 8'hFE};
        foreach (lead[i])
            fill_order.insert(fill_order.size(), lead[i]);
        for (int v = 0; v < SYMBOL_COUNT; v++)
        begin
            if (!(v inside {8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F, 8'hFE}))
                rest.insert(rest.size(), v[7:0]);
        end
        while (rest.size() > 0)
        begin
            idx = $urandom_range(0, rest.size() - 1);
            fill_order.insert(fill_order.size(), rest[idx]);
            rest.delete(idx);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Every code once, so the list of once-seen symbols ends up full.
        foreach (fill_order[i])
            send_symbol(fill_order[i]);

        // Removal of the head, the tail and a middle entry, a symbol already repeated, then the new head.
        send_symbol(8'h00);
        send_symbol(fill_order[SYMBOL_COUNT - 1]);
        send_symbol(8'h55);
        send_symbol(8'h00);
        send_symbol(8'hFF);

        guard = 0;
        while (sb.once_seen.size() > 0 && guard < 4000)
        begin
            guard++;
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    idx = 0;
                else
                    idx = $urandom_range(0, sb.once_seen.size() - 1);
                send_symbol(sb.once_seen[idx]);
            end
            else
                send_symbol(8'($urandom_range(0, SYMBOL_COUNT - 1)));
        end

        // With the list empty every symbol is repeated and the result stays not found.
        while (sent_count < ITEM_COUNT)
            send_symbol(8'($urandom_range(0, SYMBOL_COUNT - 1)));
        item_valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
